>>> rtl/core/ths_pkg.sv
// Package for the tracked handle set unit: sizes, codes and shared types.
// Used by every module under rtl/core; depends on nothing else.
package ths_pkg;

  // List size and derived widths
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned ACT_W    = 2;
  localparam int unsigned STAT_W   = 2;

  // Command queue between front and back (depth must be a power of two)
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // Stream payload widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = ((HANDLE_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((STAT_W + HANDLE_W + 7) / 8) * 8;

  // Action codes as they arrive on the input stream
  localparam logic [ACT_W-1:0] ACT_INSERT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd2;

  // Classified operation handed to the back end
  typedef enum logic [1:0] {
    OP_INSERT,
    OP_RELEASE,
    OP_CLEAR,
    OP_IGNORE
  } op_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_HELD    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  // Back end sequencer states
  typedef enum logic {
    BK_CMD,
    BK_CLEAR
  } bk_state_e;

  typedef struct packed {
    op_e                 op;
    logic [HANDLE_W-1:0] handle;
  } cmd_t;

  typedef struct packed {
    status_e             status;
    logic [HANDLE_W-1:0] handle;
    logic                valid;
    logic                last;
  } result_t;

  // Back end status seen by the top level
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             clearing;
  } back_stat_t;

endpackage

>>> rtl/core/ths_front.sv
// Front end of the tracked handle set unit: accepts input transactions and
// classifies the action code into a queued command. Depends on ths_pkg.
module ths_front (
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [ths_pkg::IN_DATA_W-1:0] s_axis_tdata_i,  // handle
  input  logic [ths_pkg::ACT_W-1:0]    s_axis_tuser_i,  // action
  input  logic                         fifo_full_i,
  output logic                         push_o,
  output ths_pkg::cmd_t                cmd_o
);

  ths_pkg::op_e op;

  // Decode the action; the unused code becomes a no-op
  always_comb begin
    case (s_axis_tuser_i)
      ths_pkg::ACT_INSERT:  op = ths_pkg::OP_INSERT;
      ths_pkg::ACT_RELEASE: op = ths_pkg::OP_RELEASE;
      ths_pkg::ACT_CLEAR:   op = ths_pkg::OP_CLEAR;
      default:              op = ths_pkg::OP_IGNORE;
    endcase
  end

  // Handshake: take a transaction whenever the queue has room
  assign s_axis_tready_o = !fifo_full_i;
  assign push_o          = s_axis_tvalid_i && !fifo_full_i;
  assign cmd_o.op        = op;
  assign cmd_o.handle    = s_axis_tdata_i[ths_pkg::HANDLE_W-1:0];

endmodule

>>> rtl/core/ths_cmd_fifo.sv
// Short command queue between front and back end of the handle set unit.
// Depends on ths_pkg for the command type and depth.
module ths_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ths_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output ths_pkg::cmd_t cmd_o,
  output logic          empty_o
);

  ths_pkg::cmd_t                   slots_q [ths_pkg::FIFO_DEPTH];
  logic [ths_pkg::PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [ths_pkg::PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [ths_pkg::FCNT_W-1:0]      cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign full_o  = (cnt_q == ths_pkg::FCNT_W'(ths_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = slots_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> rtl/core/ths_back.sv
// Back end of the handle set unit: holds the handle list, compares all held
// entries in parallel, shifts on release and clear, registers each result.
// Depends on ths_pkg.
module ths_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ths_pkg::cmd_t       cmd_i,
  input  logic                cmd_valid_i,
  output logic                cmd_pop_o,
  output ths_pkg::result_t    res_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output ths_pkg::back_stat_t stat_o
);

  localparam int unsigned CAP = ths_pkg::CAPACITY;

  logic [ths_pkg::HANDLE_W-1:0] entries_q [CAP];
  logic [ths_pkg::CNT_W-1:0]    count_q, count_d;
  ths_pkg::bk_state_e           state_q, state_d;
  ths_pkg::result_t             out_q, out_d;
  logic                         out_valid_q, out_valid_d;

  logic                         out_free;
  logic                         load;
  logic [CAP-1:0]               match;
  logic [CAP-1:0]               from_match;
  logic                         any_match;
  logic [CAP-1:0]               shift_vec;
  logic [CAP-1:0]               wr_vec;

  // Bits 0..k set
  function automatic logic [CAP-1:0] lo_mask(input int unsigned k);
    logic [CAP-1:0] m;
    m = '0;
    for (int unsigned j = 0; j < CAP; j++) begin
      m[j] = (j <= k);
    end
    return m;
  endfunction

  assign out_free = !out_valid_q || res_ready_i;

  // Parallel compare over held entries only
  always_comb begin
    for (int unsigned k = 0; k < CAP; k++) begin
      match[k] = (ths_pkg::CNT_W'(k) < count_q) && (entries_q[k] == cmd_i.handle);
    end
  end

  // Entries at or above the hit position move down (handles are unique)
  always_comb begin
    for (int unsigned k = 0; k < CAP; k++) begin
      from_match[k] = |(match & lo_mask(k));
    end
  end

  assign any_match = |match;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ths_pkg::BK_CMD: begin
        if (cmd_valid_i && out_free && (cmd_i.op == ths_pkg::OP_CLEAR) &&
            (count_q > ths_pkg::CNT_W'(1))) begin
          state_d = ths_pkg::BK_CLEAR;
        end
      end
      ths_pkg::BK_CLEAR: begin
        if (out_free && (count_q <= ths_pkg::CNT_W'(1))) begin
          state_d = ths_pkg::BK_CMD;
        end
      end
      default: state_d = ths_pkg::BK_CMD;
    endcase
  end

  // Command execution and result formation
  always_comb begin
    cmd_pop_o    = 1'b0;
    load         = 1'b0;
    count_d      = count_q;
    shift_vec    = '0;
    wr_vec       = '0;
    out_d.status = ths_pkg::ST_OK;
    out_d.handle = '0;
    out_d.valid  = 1'b0;
    out_d.last   = 1'b1;
    case (state_q)
      ths_pkg::BK_CMD: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          load      = 1'b1;
          case (cmd_i.op)
            ths_pkg::OP_INSERT: begin
              if (count_q >= ths_pkg::CNT_W'(CAP)) begin
                out_d.status = ths_pkg::ST_FULL;
              end else if (any_match) begin
                out_d.status = ths_pkg::ST_HELD;
              end else begin
                for (int unsigned k = 0; k < CAP; k++) begin
                  wr_vec[k] = (ths_pkg::CNT_W'(k) == count_q);
                end
                count_d = count_q + 1'b1;
              end
            end
            ths_pkg::OP_RELEASE: begin
              if (any_match) begin
                shift_vec = from_match;
                count_d   = count_q - 1'b1;
              end else begin
                out_d.status = ths_pkg::ST_MISSING;
              end
            end
            ths_pkg::OP_CLEAR: begin
              if (count_q != '0) begin
                out_d.handle = entries_q[0];
                out_d.valid  = 1'b1;
                out_d.last   = (count_q == ths_pkg::CNT_W'(1));
                shift_vec    = '1;
                count_d      = count_q - 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ths_pkg::BK_CLEAR: begin
        // Emit the head entry and shift the list down each cycle that the result register is free
        if (out_free) begin
          load         = 1'b1;
          out_d.handle = entries_q[0];
          out_d.valid  = 1'b1;
          out_d.last   = (count_q <= ths_pkg::CNT_W'(1));
          shift_vec    = '1;
          count_d      = count_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = load ? 1'b1 : (res_ready_i ? 1'b0 : out_valid_q);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ths_pkg::BK_CMD;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  // Handle list: append at the count position, shift down from a position
  always_ff @(posedge clk_i) begin
    for (int unsigned k = 0; k < CAP; k++) begin
      if (wr_vec[k]) begin
        entries_q[k] <= cmd_i.handle;
      end else if (shift_vec[k] && (k + 1 < CAP)) begin
        entries_q[k] <= entries_q[(k + 1 < CAP) ? k + 1 : k];
      end
    end
  end

  assign res_o           = out_q;
  assign res_valid_o     = out_valid_q;
  assign stat_o.count    = count_q;
  assign stat_o.clearing = (state_q == ths_pkg::BK_CLEAR);

endmodule

>>> rtl/core/tracked_handle_set_unit.sv
// Tracked handle set unit. Each accepted input transaction is queued in the command
// FIFO, then executed by the back end, which registers its result.
// Insert, release and ignored codes each give one result; a clear of n held handles
// gives max(n,1) results, set by the one-entry-per-cycle shift while the output is not stalled.
// Reset: asynchronous, active low; empties the list and the queue; stored
// handles are not cleared.
module tracked_handle_set_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [ths_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,  // [31:0] handle
  input  logic [ths_pkg::ACT_W-1:0]     s_axis_tuser_i,  // [1:0] action
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [ths_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,  // [1:0] status, [33:2] released_handle
  output logic [0:0]                    m_axis_tuser_o,  // [0] handle_valid
  output logic                          m_axis_tlast_o
);

  ths_pkg::cmd_t       push_cmd, head_cmd;
  logic                push, fifo_full, fifo_empty, pop;
  ths_pkg::result_t    res;
  ths_pkg::back_stat_t bk_stat;

  // Accept and classify
  ths_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .fifo_full_i     (fifo_full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  // Decoupling queue
  ths_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (fifo_empty)
  );

  // List storage and execution
  ths_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .cmd_valid_i (!fifo_empty),
    .cmd_pop_o   (pop),
    .res_o       (res),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .stat_o      (bk_stat)
  );

  // Output packing
  assign m_axis_tdata_o    = ths_pkg::OUT_DATA_W'({res.handle, res.status});
  assign m_axis_tuser_o[0] = res.valid;
  assign m_axis_tlast_o    = res.last;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.count <= ths_pkg::CNT_W'(ths_pkg::CAPACITY))
    else $error("held count exceeds capacity");

  a_clear_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=>
    (m_axis_tvalid_o && m_axis_tuser_o[0]))
    else $error("clear run broke before its last handle");

  a_nonlast_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |-> (m_axis_tuser_o[0] && bk_stat.clearing))
    else $error("non-last result outside a clear run");
`endif

endmodule
